// ----- design/keyed_table_insert_delete_lookup_core_defines.svh -----
// Assertion macros shared by the keyed table design.
`ifndef KEYED_TABLE_INSERT_DELETE_LOOKUP_CORE_DEFINES_SVH
`define KEYED_TABLE_INSERT_DELETE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kt assertion failed");

// Next-cycle implication, checked out of reset.
`define KT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kt assertion failed");

`endif

// ----- design/kt_pkg.sv -----
package kt_pkg;

	localparam int DEPTH      = 512;
	localparam int DATA_WIDTH = 32;
	localparam int KEY_W      = 64;
	localparam int WD_W       = 32;
	localparam int CNT_W      = 10;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DCNT_W     = $clog2(DEPTH + 1);
	localparam int CMP_W      = (DCNT_W > CNT_W) ? DCNT_W : CNT_W;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_DEL   = 2'd1;
	localparam logic [1:0] OP_FIND  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(512);

	typedef struct packed {
		logic                    valid;
		logic [KEY_W-1:0]        key;
		logic [DATA_WIDTH-1:0]   value;
	} entry_t;

endpackage

// ----- design/kt_req_if.sv -----
interface kt_req_if;
	import kt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                op;
	logic signed [KEY_W-1:0]   key;
	logic [WD_W-1:0]           write_data;

	modport source (output valid, output op, output key, output write_data, input ready);
	modport sink   (input valid, input op, input key, input write_data, output ready);

endinterface

// ----- design/kt_rsp_if.sv -----
interface kt_rsp_if;
	import kt_pkg::*;

	logic               valid;
	logic               ready;
	logic               ok;
	logic [WD_W-1:0]    read_data;
	logic [CNT_W-1:0]   entry_count;

	modport source (output valid, output ok, output read_data, output entry_count, input ready);
	modport sink   (input valid, input ok, input read_data, input entry_count, output ready);

endinterface

// ----- design/kt_cell.sv -----
module kt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  logic           clear,
	input  kt_pkg::entry_t d,
	output kt_pkg::entry_t q
);
	import kt_pkg::*;

	logic                  valid_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_WIDTH-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= d.key;
			value_q <= d.value;
		end
	end

	assign q = '{valid: valid_q, key: key_q, value: value_q};

endmodule

// ----- design/keyed_table_insert_delete_lookup_core.sv -----
// Channel  Dir   Beat fields                       Handshake
// req      in    op, key, write_data               valid / ready
// rsp      out   ok, read_data, entry_count        valid / ready
// cfg      in    cfg_wdata (capacity)              cfg_we, no wait
//
// The table is a ring of DEPTH cells that rotates one cell per cycle during a pass, past
// a single key compare at the head. Find, delete and an add of a held key make one pass,
// an add of a new key two (a duplicate check pass, then a placing pass),
// and clear or an add to a full table none.
// Reset clears every valid bit at once; no clearing pass.
// The next request beat is taken once the current result has moved to the output register.
module keyed_table_insert_delete_lookup_core (
	input  logic                      clk,
	input  logic                      arst_n,
	kt_req_if.sink                    req,
	kt_rsp_if.source                  rsp,
	input  logic                      cfg_we,
	input  logic [kt_pkg::CNT_W-1:0]  cfg_wdata
);
	import kt_pkg::*;
	`include "keyed_table_insert_delete_lookup_core_defines.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_INS  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(DEPTH - 1);

	logic [1:0]            state_q;
	logic [1:0]            op_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_WIDTH-1:0] wd_q;
	logic [IDX_W-1:0]      step_q;
	logic                  found_q;
	logic                  ins_done_q;
	logic [DCNT_W-1:0]     count_q;
	logic [CNT_W-1:0]      cap_q;
	logic                  res_ok_q;
	logic [WD_W-1:0]       res_rd_q;

	logic                  out_valid_q;
	logic                  out_ok_q;
	logic [WD_W-1:0]       out_rd_q;
	logic [CNT_W-1:0]      out_cnt_q;

	entry_t                cell_q [DEPTH];
	entry_t                head;
	entry_t                fb;
	logic                  shift;
	logic                  clear;
	logic                  accept;
	logic                  hit;
	logic                  hit_any;
	logic                  last;
	logic                  full;
	logic                  out_load;
	logic [CMP_W-1:0]      cap_w;
	logic [CMP_W-1:0]      limit;

	assign head     = cell_q[0];
	assign accept   = req.valid && req.ready;
	assign clear    = accept && (req.op == OP_CLEAR);
	assign shift    = (state_q == ST_SCAN) || (state_q == ST_INS);
	assign hit      = head.valid && (head.key == key_q);
	assign hit_any  = found_q || hit;
	assign last     = (step_q == STEP_LAST);
	assign cap_w    = CMP_W'(cap_q);
	assign limit    = (cap_w < CMP_W'(DEPTH)) ? cap_w : CMP_W'(DEPTH);
	assign full     = CMP_W'(count_q) >= limit;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		fb = head;
		if ((state_q == ST_SCAN) && (op_q == OP_DEL) && hit) begin
			fb.valid = 1'b0;
		end
		if ((state_q == ST_INS) && !head.valid && !ins_done_q) begin
			fb = '{valid: 1'b1, key: key_q, value: wd_q};
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t d;
		if (i == DEPTH - 1) begin : g_tail
			assign d = fb;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		kt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.clear  (clear),
			.d      (d),
			.q      (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.op == OP_CLEAR) begin
							count_q <= '0;
							state_q <= ST_DONE;
						end else if ((req.op == OP_ADD) && full) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last) begin
						if (op_q == OP_ADD && !hit_any) begin
							state_q <= ST_INS;
						end else begin
							state_q <= ST_DONE;
						end
						if (op_q == OP_DEL && hit_any && count_q != '0) begin
							count_q <= count_q - DCNT_W'(1);
						end
					end
				end
				ST_INS: begin
					if (last) begin
						count_q <= count_q + DCNT_W'(1);
						state_q <= ST_DONE;
					end
				end
				default: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= req.op;
					key_q    <= req.key;
					wd_q     <= DATA_WIDTH'(req.write_data);
					step_q   <= '0;
					found_q  <= 1'b0;
					res_ok_q <= (req.op == OP_CLEAR);
					res_rd_q <= '0;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					found_q <= 1'b1;
					if (op_q == OP_FIND) begin
						res_rd_q <= WD_W'(head.value);
					end
				end
				if (last) begin
					step_q     <= '0;
					ins_done_q <= 1'b0;
					res_ok_q   <= (op_q != OP_ADD) && hit_any;
				end else begin
					step_q <= step_q + IDX_W'(1);
				end
			end
			ST_INS: begin
				step_q <= step_q + IDX_W'(1);
				if (!head.valid) begin
					ins_done_q <= 1'b1;
				end
				if (last) begin
					res_ok_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q  <= res_ok_q;
			out_rd_q  <= res_rd_q;
			out_cnt_q <= CNT_W'(count_q);
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.ok          = out_ok_q;
	assign rsp.read_data   = out_rd_q;
	assign rsp.entry_count = out_cnt_q;

	`KT_ASSERT_IMP(a_count_bound, 1'b1, CMP_W'(count_q) <= CMP_W'(DEPTH))
	`KT_ASSERT_NXT(a_clear_empties, clear, count_q == '0)
	`KT_ASSERT_IMP(a_ins_placed, (state_q == ST_INS) && last, ins_done_q || !head.valid)

endmodule
